@@ design/sfaf_pkg.sv @@
// ----------------------------------------------------------------------------
// sfaf_pkg
// shared types, widths and codes of the staging frequency admission filter
// ----------------------------------------------------------------------------
package sfaf_pkg;

   localparam int SECTOR_W          = 48;
   localparam int KEY_W             = 48;
   localparam int SHIFT_W           = 5;
   localparam int THRESH_W          = 8;
   localparam int DECISION_W        = 2;
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 8;
   localparam int STAGE_ENTRIES_DEF = 64;
   localparam int COUNT_BITS_DEF    = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ADMISSION_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SHIFT_BITS = 2'd2;

   // decision codes
   localparam logic [DECISION_W-1:0] DEC_NONE       = 2'd0;
   localparam logic [DECISION_W-1:0] DEC_ADMIT      = 2'd1;
   localparam logic [DECISION_W-1:0] DEC_HIT        = 2'd2;
   localparam logic [DECISION_W-1:0] DEC_HIT_ADMIT  = 2'd3;

   typedef struct packed {
      logic [SECTOR_W-1:0] sector_addr;
      logic                is_read;
   } req_type;

   typedef struct packed {
      logic [DECISION_W-1:0] decision;
      logic [KEY_W-1:0]      block_key;
      logic                  evicted_valid;
      logic [KEY_W-1:0]      evicted_key;
   } rsp_type;

   typedef struct packed {
      logic                admission_mode;
      logic [THRESH_W-1:0] count_threshold;
      logic [SHIFT_W-1:0]  block_shift_bits;
   } cfg_type;

endpackage

@@ design/sfaf_ram.sv @@
// ----------------------------------------------------------------------------
// sfaf_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sfaf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sfaf_csr.sv @@
// ----------------------------------------------------------------------------
// sfaf_csr
// configuration registers of the admission filter
// ----------------------------------------------------------------------------
module sfaf_csr import sfaf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.admission_mode   <= 1'b0;
         cfg_ff.count_threshold  <= THRESH_W'(2);
         cfg_ff.block_shift_bits <= SHIFT_W'(3);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ADMISSION_MODE:   cfg_ff.admission_mode   <= csr_data[0];
            CSR_COUNT_THRESHOLD:  cfg_ff.count_threshold  <= csr_data[THRESH_W-1:0];
            CSR_BLOCK_SHIFT_BITS: cfg_ff.block_shift_bits <= csr_data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/staging_frequency_admission_filter.sv @@
// ----------------------------------------------------------------------------
// staging_frequency_admission_filter
// lru staging table with a saturating access count per block key
// ----------------------------------------------------------------------------
// One item (sector access) is taken at a time. Its block key is searched in
// the staging table from the lru end, one position per cycle through a single
// record ram, then the table is reordered by moving records one position per
// cycle through the same ram port pair. On an admit the record goes to the
// lru end, otherwise to the recent end. The result becomes valid in the same
// cycle that the next item can be taken, and the result of an item waits in
// the sequencer while an earlier result is stalled at the output. The result
// sits in an output register, so the next item may be taken while it waits.
// No clearing pass is needed: records are held in lru position order and only
// per-position valid flops are cleared at reset.
// ----------------------------------------------------------------------------
module staging_frequency_admission_filter import sfaf_pkg::*; #(
   parameter int STAGE_ENTRIES = STAGE_ENTRIES_DEF,
   parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W = $clog2(STAGE_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int REC_W = KEY_W + COUNT_BITS + 1;
   localparam int CMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;
   localparam logic [IDX_W-1:0]      LAST_POS  = IDX_W'(STAGE_ENTRIES - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_SHIFT  = 3'd3;
   localparam logic [2:0] ST_FINAL  = 3'd4;
   localparam logic [2:0] ST_OUT    = 3'd5;

   cfg_type cfg;

   logic [2:0] state_ff, state_in;

   // item being worked on
   logic [KEY_W-1:0] key_ff;
   logic             rd_ff;

   // search walk
   logic [CNT_W-1:0] issue_ff;
   logic             chk_v_ff;
   logic [IDX_W-1:0] chk_pos_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_pos_ff;
   logic [KEY_W-1:0] ev0_key_ff;
   logic [IDX_W-1:0] hit_pos_ff;
   logic [COUNT_BITS-1:0] hit_cnt_ff;
   logic             hit_data_ff;
   logic             hit_ff;

   // update result
   logic [REC_W-1:0]      rec_ff;
   logic                  to_lru_ff;
   logic [IDX_W-1:0]      mv_pos_ff;
   logic [DECISION_W-1:0] dec_ff;
   logic                  evv_ff;
   logic [KEY_W-1:0]      evk_ff;

   // reorder walk
   logic [IDX_W-1:0] src_ff;
   logic [IDX_W-1:0] dst_ff;
   logic [IDX_W-1:0] rem_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] pend_addr_ff;

   // per-position valid bits, position 0 is the lru end
   logic [STAGE_ENTRIES-1:0] valid_ff, valid_in;

   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   // record ram, one record per lru position: {key, count, data staged}
   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [REC_W-1:0] ram_wdata;
   logic [IDX_W-1:0] ram_raddr;
   logic [REC_W-1:0] ram_rdata;
   logic [KEY_W-1:0] rd_key;
   logic [COUNT_BITS-1:0] rd_cnt;
   logic             rd_data_bit;

   logic                  search_hit;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic                  admit;
   logic                  data_mode_read;
   logic [IDX_W-1:0]      use_pos;
   logic                  req_take;
   logic                  rsp_load;

   sfaf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfaf_ram #(
      .WIDTH (REC_W),
      .DEPTH (STAGE_ENTRIES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (1'b1),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_key      = ram_rdata[REC_W-1 -: KEY_W];
   assign rd_cnt      = ram_rdata[COUNT_BITS:1];
   assign rd_data_bit = ram_rdata[0];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // compare stage of the search walk
   assign search_hit = chk_v_ff && valid_ff[chk_pos_ff] && (rd_key == key_ff);

   // hit arithmetic, one saturating add and one compare
   assign cnt_inc        = (hit_cnt_ff == COUNT_MAX) ? hit_cnt_ff : hit_cnt_ff + 1'b1;
   assign admit          = CMP_W'(cnt_inc) > CMP_W'(cfg.count_threshold);
   assign data_mode_read = cfg.admission_mode && rd_ff;
   // first free position from the lru end, else the lru entry is evicted
   assign use_pos        = free_found_ff ? free_pos_ff : '0;

   // ram port selection
   always_comb begin
      ram_raddr = (state_ff == ST_SEARCH) ? issue_ff[IDX_W-1:0] : src_ff;
      ram_we    = 1'b0;
      ram_waddr = pend_addr_ff;
      ram_wdata = ram_rdata;
      if (state_ff == ST_SHIFT && pend_ff) begin
         ram_we = 1'b1;
      end else if (state_ff == ST_FINAL) begin
         ram_we    = 1'b1;
         ram_waddr = to_lru_ff ? '0 : LAST_POS;
         ram_wdata = rec_ff;
      end
   end

   // valid bits follow the record move
   always_comb begin
      for (int q = 0; q < STAGE_ENTRIES; q++) begin
         if (to_lru_ff) begin
            if (IDX_W'(q) > mv_pos_ff) valid_in[q] = valid_ff[q];
            else if (q == 0)           valid_in[q] = 1'b1;
            else                       valid_in[q] = valid_ff[(q == 0) ? 0 : q - 1];
         end else begin
            if (IDX_W'(q) < mv_pos_ff)      valid_in[q] = valid_ff[q];
            else if (q == STAGE_ENTRIES - 1) valid_in[q] = 1'b1;
            else valid_in[q] = valid_ff[(q == STAGE_ENTRIES - 1) ? q : q + 1];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_take) state_in = ST_SEARCH;
         ST_SEARCH: if (search_hit || (chk_v_ff && chk_pos_ff == LAST_POS))
                       state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_SHIFT;
         ST_SHIFT:  if (rem_ff == '0 && !pend_ff) state_in = ST_FINAL;
         ST_FINAL:  state_in = ST_OUT;
         ST_OUT:    if (rsp_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         chk_v_ff     <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FINAL) begin
            valid_ff <= valid_in;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_SEARCH) begin
            chk_v_ff <= issue_ff < CNT_W'(STAGE_ENTRIES);
         end else begin
            chk_v_ff <= 1'b0;
         end
         if (state_ff == ST_SHIFT) begin
            pend_ff <= (rem_ff != '0);
         end else begin
            pend_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            key_ff        <= KEY_W'(req_data.sector_addr >> cfg.block_shift_bits);
            rd_ff         <= req_data.is_read;
            issue_ff      <= '0;
            free_found_ff <= 1'b0;
            hit_ff        <= 1'b0;
         end
         ST_SEARCH: begin
            if (issue_ff < CNT_W'(STAGE_ENTRIES)) issue_ff <= issue_ff + 1'b1;
            chk_pos_ff <= issue_ff[IDX_W-1:0];
            if (chk_v_ff) begin
               if (chk_pos_ff == '0) ev0_key_ff <= rd_key;
               if (!valid_ff[chk_pos_ff] && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_pos_ff   <= chk_pos_ff;
               end
               if (search_hit) begin
                  hit_ff      <= 1'b1;
                  hit_pos_ff  <= chk_pos_ff;
                  hit_cnt_ff  <= rd_cnt;
                  hit_data_ff <= rd_data_bit;
               end
            end
         end
         ST_UPDATE: begin
            if (hit_ff) begin
               rec_ff    <= {key_ff, cnt_inc, data_mode_read | hit_data_ff};
               to_lru_ff <= admit;
               mv_pos_ff <= hit_pos_ff;
               evv_ff    <= 1'b0;
               evk_ff    <= '0;
               if (data_mode_read && hit_data_ff) dec_ff <= admit ? DEC_HIT_ADMIT : DEC_HIT;
               else                               dec_ff <= admit ? DEC_ADMIT : DEC_NONE;
               dst_ff <= hit_pos_ff;
               if (admit) begin
                  src_ff <= hit_pos_ff - 1'b1;
                  rem_ff <= hit_pos_ff;
               end else begin
                  src_ff <= hit_pos_ff + 1'b1;
                  rem_ff <= LAST_POS - hit_pos_ff;
               end
            end else begin
               rec_ff    <= {key_ff, COUNT_BITS'(1), data_mode_read};
               to_lru_ff <= 1'b0;
               mv_pos_ff <= use_pos;
               evv_ff    <= !free_found_ff;
               evk_ff    <= free_found_ff ? '0 : ev0_key_ff;
               dec_ff    <= DEC_NONE;
               dst_ff    <= use_pos;
               src_ff    <= use_pos + 1'b1;
               rem_ff    <= LAST_POS - use_pos;
            end
         end
         ST_SHIFT: begin
            if (rem_ff != '0) begin
               src_ff       <= to_lru_ff ? src_ff - 1'b1 : src_ff + 1'b1;
               dst_ff       <= to_lru_ff ? dst_ff - 1'b1 : dst_ff + 1'b1;
               rem_ff       <= rem_ff - 1'b1;
               pend_addr_ff <= dst_ff;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_ff.decision      <= dec_ff;
               rsp_ff.block_key     <= key_ff;
               rsp_ff.evicted_valid <= evv_ff;
               rsp_ff.evicted_key   <= evk_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted item always starts a search walk
   a_take_search: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_SEARCH)
      else $error("accepted item did not start a search");

   // the reorder walk ends once all moves are written
   a_shift_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && rem_ff == '0 && !pend_ff) |=> state_ff == ST_FINAL)
      else $error("reorder walk did not finish");

   // a record written back never has a zero count
   a_rec_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINAL |-> rec_ff[COUNT_BITS:1] != '0)
      else $error("zero count written to staging table");

   // an eviction only happens when the table is full
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL && evv_ff) |-> valid_ff == '1)
      else $error("eviction with a free entry");

endmodule
